>>> hdl/obb_pkg.sv
package obb_pkg;

  localparam int COORD_W = 24;
  localparam int AXIS_W  = 16;
  localparam int LEN_W   = 21;
  localparam int DIFF_W  = 25;
  localparam int LOCAL_W = 44;
  localparam int EX_W    = 32;
  localparam int SQ_W    = 66;
  localparam int ROOT_W  = 33;
  localparam int BACK_W  = 63;
  localparam int DIST_W  = 25;
  localparam int CFG_W   = 63;
  localparam int CFG_IDX_W = 3;
  localparam int RIM_TOLERANCE = 1;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_0   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_1   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_2   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTHS  = 3'd6;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      rim_mode;
  } query_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] closest_x;
    logic signed [COORD_W-1:0] closest_y;
    logic signed [COORD_W-1:0] closest_z;
    logic [DIST_W-1:0]         distance;
    logic                      inside_flag;
  } result_t;

  typedef struct packed {
    logic signed [2:0][COORD_W-1:0]          center;
    logic signed [2:0][2:0][AXIS_W-1:0]      axis;   // [d][k]
    logic [2:0][LEN_W-1:0]                   len;
  } box_t;

endpackage

>>> hdl/obb_isqrt.sv
// Pipelined floor square root, one result bit per stage.
module obb_isqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [obb_pkg::SQ_W-1:0]       radicand,
  input  logic [obb_pkg::COORD_W*3:0]    side_in,
  output logic                           out_valid,
  output logic [obb_pkg::ROOT_W-1:0]     root,
  output logic [obb_pkg::COORD_W*3:0]    side_out
);
  localparam int N = obb_pkg::ROOT_W;
  localparam int RW = obb_pkg::SQ_W + 2;

  logic                          vld  [N+1];
  logic [RW-1:0]                 rem  [N+1];
  logic [obb_pkg::SQ_W-1:0]      rad  [N+1];
  logic [N-1:0]                  q    [N+1];
  logic [obb_pkg::COORD_W*3:0]   side [N+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = '0;
  assign rad[0]  = radicand;
  assign q[0]    = '0;
  assign side[0] = side_in;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [RW-1:0] trial;
    logic [RW-1:0] shifted;
    logic [obb_pkg::SQ_W-1:0] pair_rad;
    always_comb begin
      shifted = {rem[i][RW-3:0], rad[i][obb_pkg::SQ_W-1 -: 2]};
      trial = RW'({q[i], 2'b01});
      pair_rad = {rad[i][obb_pkg::SQ_W-3:0], 2'b00};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      rad[i+1]  <= pair_rad;
      side[i+1] <= side[i];
      if (shifted >= trial) begin
        rem[i+1] <= shifted - trial;
        q[i+1]   <= {q[i][N-2:0], 1'b1};
      end else begin
        rem[i+1] <= shifted;
        q[i+1]   <= {q[i][N-2:0], 1'b0};
      end
    end
  end

  assign out_valid = vld[N];
  assign root      = q[N];
  assign side_out  = side[N];

  a_root_chain: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> ##33 out_valid) else $error("root valid lost");
  a_root_spurious: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> ##33 !out_valid) else $error("root spurious valid");
  a_root_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown(out_valid)) else $error("root valid unknown");
endmodule

>>> hdl/obb_geom.sv
// Front pipeline: difference, local projection, clamp, back transform,
// squared excess. Six register stages.
module obb_geom (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  obb_pkg::query_t               query,
  input  obb_pkg::box_t                 box,
  output logic                          out_valid,
  output logic [obb_pkg::SQ_W-1:0]      sumsq,
  output logic [obb_pkg::COORD_W*3:0]   side
);
  localparam int PW = obb_pkg::AXIS_W + obb_pkg::DIFF_W;
  localparam int HW = obb_pkg::LEN_W + 14;

  // stage 1: differences
  logic v1;
  logic signed [2:0][obb_pkg::DIFF_W-1:0] diff1;
  logic rim1;
  // stage 2: products axis[d][k]*diff[k]
  logic v2;
  logic signed [2:0][2:0][PW-1:0] prod2;
  logic rim2;
  // stage 3: local coordinates
  logic v3;
  logic signed [2:0][obb_pkg::LOCAL_W-1:0] loc3;
  logic rim3;
  // stage 4: clamped and excess, inside flag
  logic v4;
  logic signed [2:0][HW-1:0] clamp4;
  logic [2:0][obb_pkg::EX_W-1:0] ex4;
  logic in4;
  // stage 5: back products, excess squares
  logic v5;
  logic signed [2:0][2:0][obb_pkg::AXIS_W+HW-1:0] bp5;
  logic [2:0][2*obb_pkg::EX_W-1:0] sq5;
  logic in5;
  // stage 6: back sums, sumsq
  logic v6;
  logic signed [2:0][obb_pkg::COORD_W-1:0] cp6;
  logic [obb_pkg::SQ_W-1:0] ss6;
  logic in6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
    end else begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    diff1[0] <= obb_pkg::DIFF_W'(query.point_x)
              - obb_pkg::DIFF_W'($signed(box.center[0]));
    diff1[1] <= obb_pkg::DIFF_W'(query.point_y)
              - obb_pkg::DIFF_W'($signed(box.center[1]));
    diff1[2] <= obb_pkg::DIFF_W'(query.point_z)
              - obb_pkg::DIFF_W'($signed(box.center[2]));
    rim1 <= query.rim_mode;
  end

  always_ff @(posedge clk) begin
    for (int d = 0; d < 3; d++) begin
      for (int k = 0; k < 3; k++) begin
        prod2[d][k] <= PW'($signed(box.axis[d][k])) * PW'($signed(diff1[k]));
      end
    end
    rim2 <= rim1;
  end

  always_ff @(posedge clk) begin
    for (int d = 0; d < 3; d++) begin
      loc3[d] <= obb_pkg::LOCAL_W'($signed(prod2[d][0]))
               + obb_pkg::LOCAL_W'($signed(prod2[d][1]))
               + obb_pkg::LOCAL_W'($signed(prod2[d][2]));
    end
    rim3 <= rim2;
  end

  always_ff @(posedge clk) begin
    logic signed [obb_pkg::LOCAL_W-1:0] lc, hi, lim, cl, e;
    logic ins;
    ins = 1'b1;
    for (int d = 0; d < 3; d++) begin
      lc  = $signed(loc3[d]);
      hi  = obb_pkg::LOCAL_W'({box.len[d], 13'd0});
      lim = hi + (rim3 ? obb_pkg::LOCAL_W'(obb_pkg::RIM_TOLERANCE) <<< 14
                       : obb_pkg::LOCAL_W'(0));
      if (lc > lim || lc < -lim) ins = 1'b0;
      cl = (lc > hi) ? hi : ((lc < -hi) ? -hi : lc);
      e  = (lc >= cl) ? lc - cl : cl - lc;
      clamp4[d] <= HW'(cl);
      ex4[d]    <= obb_pkg::EX_W'(e >>> 12);
    end
    in4 <= ins;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      for (int d = 0; d < 3; d++) begin
        bp5[k][d] <= (obb_pkg::AXIS_W+HW)'($signed(box.axis[d][k]))
                   * (obb_pkg::AXIS_W+HW)'($signed(clamp4[d]));
      end
      sq5[k] <= ex4[k] * ex4[k];
    end
    in5 <= in4;
  end

  always_ff @(posedge clk) begin
    logic signed [obb_pkg::BACK_W-1:0] acc, v;
    for (int k = 0; k < 3; k++) begin
      acc = obb_pkg::BACK_W'($signed(bp5[k][0])) + obb_pkg::BACK_W'($signed(bp5[k][1]))
          + obb_pkg::BACK_W'($signed(bp5[k][2]));
      v = obb_pkg::BACK_W'($signed(box.center[k])) + (acc >>> 28);
      if (v > obb_pkg::BACK_W'(24'sh7FFFFF)) cp6[k] <= 24'sh7FFFFF;
      else if (v < -obb_pkg::BACK_W'(24'sh7FFFFF) - 1) cp6[k] <= 24'sh800000;
      else cp6[k] <= obb_pkg::COORD_W'(v);
    end
    ss6 <= obb_pkg::SQ_W'(sq5[0]) + obb_pkg::SQ_W'(sq5[1]) + obb_pkg::SQ_W'(sq5[2]);
    in6 <= in5;
  end

  assign out_valid = v6;
  assign sumsq     = ss6;
  assign side      = {cp6[0], cp6[1], cp6[2], in6};

  a_valid_chain: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> ##6 out_valid) else $error("geom valid lost");
  a_valid_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown(out_valid)) else $error("geom valid unknown");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> ##6 !out_valid) else $error("geom spurious valid");
endmodule

>>> hdl/obb_point_query.sv
// Stages: 6 geometry stages, 33 root stages, 1 output stage. Throughput:
// one item per cycle; the depth comes from the one-bit-per-stage square root.
// Results are strobed on done for one cycle and cannot be stalled.
// Synchronous reset empties the pipeline and returns the box registers to
// identity axes at the origin with zero lengths.
module obb_point_query (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  obb_pkg::query_t                      query,
  output logic                                 done,
  output obb_pkg::result_t                     result,
  input  logic                                 cfg_we,
  input  logic [obb_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [obb_pkg::CFG_W-1:0]            cfg_data
);
  obb_pkg::box_t box;
  logic g_valid, r_valid;
  logic [obb_pkg::SQ_W-1:0] sumsq;
  logic [obb_pkg::COORD_W*3:0] g_side, r_side;
  logic [obb_pkg::ROOT_W-1:0] root;
  logic [obb_pkg::ROOT_W-1:0] dist_next;
  logic done_q;
  obb_pkg::result_t result_q;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      box.center <= '0;
      box.axis   <= '0;
      box.axis[0][0] <= 16'sd16384;
      box.axis[1][1] <= 16'sd16384;
      box.axis[2][2] <= 16'sd16384;
      box.len    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        obb_pkg::REG_CENTER_X: box.center[0] <= cfg_data[23:0];
        obb_pkg::REG_CENTER_Y: box.center[1] <= cfg_data[23:0];
        obb_pkg::REG_CENTER_Z: box.center[2] <= cfg_data[23:0];
        obb_pkg::REG_AXIS_0: box.axis[0] <= cfg_data[47:0];
        obb_pkg::REG_AXIS_1: box.axis[1] <= cfg_data[47:0];
        obb_pkg::REG_AXIS_2: box.axis[2] <= cfg_data[47:0];
        obb_pkg::REG_LENGTHS: box.len <= cfg_data[62:0];
        default: ;
      endcase
    end
  end

  obb_geom u_geom (
    .clk(clk), .rst(rst), .in_valid(start & ~busy), .query(query), .box(box),
    .out_valid(g_valid), .sumsq(sumsq), .side(g_side)
  );

  obb_isqrt u_isqrt (
    .clk(clk), .rst(rst), .in_valid(g_valid), .radicand(sumsq), .side_in(g_side),
    .out_valid(r_valid), .root(root), .side_out(r_side)
  );

  assign dist_next = root >> 2;

  always_ff @(posedge clk) begin
    if (rst) begin
      done_q <= 1'b0;
    end else begin
      done_q <= r_valid;
    end
    result_q.closest_x <= r_side[72:49];
    result_q.closest_y <= r_side[48:25];
    result_q.closest_z <= r_side[24:1];
    result_q.inside_flag <= r_side[0];
    result_q.distance <= (dist_next > obb_pkg::ROOT_W'(33554431)) ? 25'h1FFFFFF
                         : dist_next[obb_pkg::DIST_W-1:0];
  end

  assign done   = done_q;
  assign result = result_q;

  a_inside_dist: assert property (@(posedge clk) disable iff (rst)
    (done && result.inside_flag && !$past(query.rim_mode, 40)) |-> result.distance == '0)
    else $error("inside point with nonzero distance");
  a_lat: assert property (@(posedge clk) disable iff (rst)
    r_valid |=> done) else $error("result dropped");
  a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
endmodule

>>> bench/tb_obb_point_query.sv
module tb_obb_point_query;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [obb_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES = 45;
  localparam longint DIST_SAT = 64'd33554431;
  localparam longint COORD_HI = 64'sd8388607;
  localparam longint COORD_LO = -64'sd8388608;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  obb_pkg::query_t  query = '0;
  logic             done;
  obb_pkg::result_t result;
  logic             cfg_we = 1'b0;
  logic [obb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [obb_pkg::CFG_W-1:0] cfg_data = '0;

  obb_pkg::query_t  pending_queries[$];
  obb_pkg::result_t expected_results[$];
  logic [obb_pkg::CFG_W-1:0] box_reg[7];
  int      errors = 0;
  int      n_checked = 0;
  int      n_inside = 0;
  int      n_configs = 0;
  int      burst_left = 0;
  int      gap_left = 0;

  obb_point_query i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .query(query),
    .done(done), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic [33:0] int_sqrt(logic [65:0] x);
    logic [67:0] rem;
    logic [67:0] res;
    logic [67:0] one_bit;
    rem = 68'(x);
    res = '0;
    one_bit = 68'd1 << 66;
    while (one_bit > rem) one_bit = one_bit >> 2;
    while (one_bit != 0) begin
      if (rem >= res + one_bit) begin
        rem = rem - (res + one_bit);
        res = (res >> 1) + one_bit;
      end else begin
        res = res >> 1;
      end
      one_bit = one_bit >> 2;
    end
    return res[33:0];
  endfunction

  // Box-frame clamp, back transform and clamp-excess distance.
  function automatic obb_pkg::result_t closest_on_box(obb_pkg::query_t q);
    longint pts[3];
    longint diff[3];
    longint clamped[3];
    longint cl_out[3];
    longint acc, hi, lim, mag, v;
    logic [65:0] ex, sumsq;
    logic [33:0] root;
    logic is_in;
    obb_pkg::result_t r;
    pts[0] = longint'(q.point_x);
    pts[1] = longint'(q.point_y);
    pts[2] = longint'(q.point_z);
    sumsq = '0;
    is_in = 1'b1;
    for (int k = 0; k < 3; k++)
      diff[k] = pts[k] - longint'($signed(box_reg[k][23:0]));
    for (int d = 0; d < 3; d++) begin
      hi = longint'(box_reg[obb_pkg::REG_LENGTHS][21*d +: 21]) << 13;
      lim = hi + (q.rim_mode ? (longint'(obb_pkg::RIM_TOLERANCE) << 14) : 0);
      acc = 0;
      for (int k = 0; k < 3; k++)
        acc += longint'($signed(box_reg[3+d][16*k +: 16])) * diff[k];
      if (acc > lim || acc < -lim) is_in = 1'b0;
      clamped[d] = acc > hi ? hi : (acc < -hi ? -hi : acc);
      mag = acc >= clamped[d] ? acc - clamped[d] : clamped[d] - acc;
      ex = 66'(mag >>> 12);
      sumsq = sumsq + ex * ex;
    end
    for (int k = 0; k < 3; k++) begin
      acc = 0;
      for (int d = 0; d < 3; d++)
        acc += longint'($signed(box_reg[3+d][16*k +: 16])) * clamped[d];
      v = longint'($signed(box_reg[k][23:0])) + (acc >>> 28);
      if (v > COORD_HI) v = COORD_HI;
      if (v < COORD_LO) v = COORD_LO;
      cl_out[k] = v;
    end
    root = int_sqrt(sumsq) >> 2;
    r.closest_x = cl_out[0][23:0];
    r.closest_y = cl_out[1][23:0];
    r.closest_z = cl_out[2][23:0];
    r.distance = (longint'(root) > DIST_SAT) ? DIST_SAT[24:0] : root[24:0];
    r.inside_flag = is_in;
    return r;
  endfunction

  // Sender: bursts of items separated by random gaps.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (pending_queries.size() > 0) begin
      start <= 1'b1;
      query <= pending_queries[0];
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 30);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        expected_results.push_back(closest_on_box(query));
        void'(pending_queries.pop_front());
      end
      if (done) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, result);
          errors++;
        end else begin
          obb_pkg::result_t exp_r;
          exp_r = expected_results.pop_front();
          n_checked++;
          if (exp_r.inside_flag) n_inside++;
          if (result.closest_x !== exp_r.closest_x) begin
            $display("%0t: closest_x expected %h got %h", $realtime, exp_r.closest_x,
                     result.closest_x);
            errors++;
          end
          if (result.closest_y !== exp_r.closest_y) begin
            $display("%0t: closest_y expected %h got %h", $realtime, exp_r.closest_y,
                     result.closest_y);
            errors++;
          end
          if (result.closest_z !== exp_r.closest_z) begin
            $display("%0t: closest_z expected %h got %h", $realtime, exp_r.closest_z,
                     result.closest_z);
            errors++;
          end
          if (result.distance !== exp_r.distance) begin
            $display("%0t: distance expected %h got %h", $realtime, exp_r.distance,
                     result.distance);
            errors++;
          end
          if (result.inside_flag !== exp_r.inside_flag) begin
            $display("%0t: inside_flag expected %b got %b", $realtime,
                     exp_r.inside_flag, result.inside_flag);
            errors++;
          end
        end
      end
    end
  end

  task automatic write_reg(logic [obb_pkg::CFG_IDX_W-1:0] idx,
                           logic [obb_pkg::CFG_W-1:0] data);
    int widths[7];
    widths = '{24, 24, 24, 48, 48, 48, 63};
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx <= obb_pkg::REG_LENGTHS)
      box_reg[idx] = data & ((63'd1 << widths[idx]) - 63'd1 | {63{widths[idx] == 63}});
    n_configs++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_point(longint x, longint y, longint z, logic rim);
    obb_pkg::query_t q;
    q.point_x = x[23:0];
    q.point_y = y[23:0];
    q.point_z = z[23:0];
    q.rim_mode = rim;
    pending_queries.push_back(q);
  endtask

  task automatic wait_drained();
    while (pending_queries.size() > 0 || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [47:0] pack_axis(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  function automatic logic [obb_pkg::CFG_W-1:0] rand_wide();
    return obb_pkg::CFG_W'({$urandom, $urandom});
  endfunction

  // Mostly points near the box, the rest anywhere in the coordinate range.
  task automatic random_points(int n);
    longint reach;
    longint c[3];
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        add_point($urandom, $urandom, $urandom, $urandom_range(0, 1));
      end else begin
        reach = longint'(1) << $urandom_range(2, 22);
        for (int k = 0; k < 3; k++)
          c[k] = longint'($signed(box_reg[k][23:0]))
                 + longint'($urandom_range(0, 2 * reach)) - reach;
        add_point(c[0], c[1], c[2], $urandom_range(0, 1));
      end
    end
  endtask

  initial begin
    box_reg[0] = '0;
    box_reg[1] = '0;
    box_reg[2] = '0;
    box_reg[3] = 63'd16384;
    box_reg[4] = 63'd16384 << 16;
    box_reg[5] = 63'd16384 << 32;
    box_reg[6] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset box: zero lengths, so the clamp range is a single point.
    add_point(0, 0, 0, 1'b0);
    add_point(0, 0, 0, 1'b1);
    add_point(4, -4, 0, 1'b1);
    add_point(8388607, 8388607, 8388607, 1'b0);
    add_point(-8388608, -8388608, -8388608, 1'b1);
    wait_drained();

    // Axis-aligned box of full length 2.0: boundary, rim tolerance, outside.
    write_reg(obb_pkg::REG_LENGTHS, {21'd8192, 21'd8192, 21'd8192});
    write_reg(REG_UNUSED, '1);
    add_point(4096, 4096, -4096, 1'b0);
    add_point(4097, 0, 0, 1'b0);
    add_point(4097, 0, 0, 1'b1);
    add_point(0, -4097, 0, 1'b1);
    add_point(0, 0, 4098, 1'b1);
    add_point(100, -200, 300, 1'b0);
    add_point(20000, -30000, 40000, 1'b0);
    add_point(8388607, -8388608, 0, 1'b1);
    wait_drained();

    // Extreme box: center at the corner, most-negative and most-positive axis entries, maximum lengths.
    write_reg(obb_pkg::REG_CENTER_X, 63'h7FFFFF);
    write_reg(obb_pkg::REG_CENTER_Y, 63'h800000);
    write_reg(obb_pkg::REG_CENTER_Z, 63'h7FFFFF);
    write_reg(obb_pkg::REG_AXIS_0, 63'h800080008000);
    write_reg(obb_pkg::REG_AXIS_1, 63'h7FFF7FFF7FFF);
    write_reg(obb_pkg::REG_AXIS_2, 63'h000080000000);
    write_reg(obb_pkg::REG_LENGTHS, '1);
    add_point(-8388608, 8388607, -8388608, 1'b0);
    add_point(8388607, -8388608, 8388607, 1'b1);
    add_point(0, 0, 0, 1'b0);
    add_point(-8388608, -8388608, -8388608, 1'b1);
    add_point(8388607, 8388607, 8388607, 1'b0);
    random_points(30);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(obb_pkg::REG_CENTER_X, 63'($urandom) >> $urandom_range(0, 12));
      write_reg(obb_pkg::REG_CENTER_Y, 63'($urandom));
      write_reg(obb_pkg::REG_CENTER_Z, 63'($urandom) >> $urandom_range(0, 12));
      if (ph % 2 == 0) begin
        // Permuted, sign-flipped unit axes keep the box orthonormal.
        write_reg(obb_pkg::REG_AXIS_0, pack_axis(0, 16384, 0));
        write_reg(obb_pkg::REG_AXIS_1, pack_axis(0, 0, (ph == 2) ? -16384 : 16384));
        write_reg(obb_pkg::REG_AXIS_2, pack_axis(-16384, 0, 0));
      end else begin
        write_reg(obb_pkg::REG_AXIS_0, rand_wide());
        write_reg(obb_pkg::REG_AXIS_1, rand_wide());
        write_reg(obb_pkg::REG_AXIS_2, rand_wide());
      end
      if (ph == 5)
        write_reg(obb_pkg::REG_LENGTHS, rand_wide());
      else
        write_reg(obb_pkg::REG_LENGTHS, {21'($urandom_range(0, 1 << (6 + 2 * ph))),
                                         21'($urandom_range(0, 1 << (8 + 2 * ph))),
                                         21'($urandom_range(0, 1 << (4 + 2 * ph)))});
      random_points(60);
      wait_drained();
    end

    $display("Checked %0d box queries (%0d inside) over %0d register writes.",
             n_checked, n_inside, n_configs);
    if (errors == 0) begin
      $display("tb_obb_point_query OK");
    end else begin
      $display("tb_obb_point_query NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding.", expected_results.size());
    $display("tb_obb_point_query NOT OK");
    $finish;
  end

endmodule

>>> files.f
hdl/obb_pkg.sv
hdl/obb_isqrt.sv
hdl/obb_geom.sv
hdl/obb_point_query.sv
bench/tb_obb_point_query.sv
